// ===== sv/png_unf_pkg.sv =====
package png_unf_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CNT_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int ROWS_W        = 15;
    localparam int LWIDTH_W      = 13;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE = 2'd0,
        CFG_LINE_WIDTH = 2'd1,
        CFG_IMAGE_ROWS = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_GRAY       = 2'd0,
        MODE_RGB        = 2'd1,
        MODE_GRAY_ALPHA = 2'd2,
        MODE_RGBA       = 2'd3
    } t_color_mode;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    localparam logic [7:0] FILT_LIMIT = 8'd5;

    typedef struct packed {
        t_color_mode        color_mode;
        logic [CNT_W-1:0]   width;
        logic [ROWS_W-1:0]  rows;
    } t_cfg;

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] i);
        return w[i*8 +: 8];
    endfunction

    function automatic logic [31:0] set_byte(input logic [31:0] w, input logic [1:0] i,
                                             input logic [7:0] v);
        logic [31:0] r;
        r = w;
        r[i*8 +: 8] = v;
        return r;
    endfunction

    function automatic logic [2:0] samples_per_pixel(input t_color_mode m);
        logic [2:0] n;
        unique case (m)
            MODE_GRAY:       n = 3'd1;
            MODE_RGB:        n = 3'd3;
            MODE_GRAY_ALPHA: n = 3'd2;
            MODE_RGBA:       n = 3'd4;
            default:         n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] to_argb(input t_color_mode m, input logic [31:0] s);
        logic [31:0] r;
        unique case (m)
            MODE_GRAY:       r = {ALPHA_OPAQUE, s[7:0], s[7:0], s[7:0]};
            MODE_RGB:        r = {ALPHA_OPAQUE, s[7:0], s[15:8], s[23:16]};
            MODE_GRAY_ALPHA: r = {s[15:8], s[7:0], s[7:0], s[7:0]};
            MODE_RGBA:       r = {s[31:24], s[7:0], s[15:8], s[23:16]};
            default:         r = {s[31:24], s[7:0], s[15:8], s[23:16]};
        endcase
        return r;
    endfunction

endpackage

// ===== sv/png_unf_ram.sv =====
module png_unf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/png_unf_cfg.sv =====
module png_unf_cfg #(
    parameter int MAX_WIDTH = png_unf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output png_unf_pkg::t_cfg                   o_cfg
);

    localparam logic [png_unf_pkg::CNT_W-1:0] MaxW = png_unf_pkg::CNT_W'(MAX_WIDTH);

    png_unf_pkg::t_color_mode            r_color_mode;
    logic [png_unf_pkg::LWIDTH_W-1:0]    r_line_width;
    logic [png_unf_pkg::ROWS_W-1:0]      r_image_rows;
    logic [png_unf_pkg::CNT_W-1:0]       w_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= png_unf_pkg::MODE_RGBA;
            r_line_width <= png_unf_pkg::LWIDTH_W'(1);
            r_image_rows <= png_unf_pkg::ROWS_W'(1);
        end else if (i_cfg_we) begin
            unique case (png_unf_pkg::t_cfg_index'(i_cfg_index))
                png_unf_pkg::CFG_COLOR_MODE:
                    r_color_mode <= png_unf_pkg::t_color_mode'(i_cfg_data[1:0]);
                png_unf_pkg::CFG_LINE_WIDTH:
                    r_line_width <= i_cfg_data[png_unf_pkg::LWIDTH_W-1:0];
                png_unf_pkg::CFG_IMAGE_ROWS:
                    r_image_rows <= i_cfg_data[png_unf_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_width = png_unf_pkg::CNT_W'(r_line_width);
        if (r_line_width == '0) begin
            w_width = png_unf_pkg::CNT_W'(1);
        end else if (w_width > MaxW) begin
            w_width = MaxW;
        end
        o_cfg.color_mode = r_color_mode;
        o_cfg.width      = w_width;
        o_cfg.rows       = (r_image_rows == '0) ? png_unf_pkg::ROWS_W'(1) : r_image_rows;
    end

endmodule

// ===== sv/png_unf_predict.sv =====
module png_unf_predict (
    input  png_unf_pkg::t_filter i_filter,
    input  logic [7:0]           i_raw,
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic [7:0]           i_c,
    output logic [7:0]           o_sample
);

    logic [8:0] w_ab;
    logic [8:0] w_cc;
    logic [7:0] w_pa;
    logic [7:0] w_pb;
    logic [8:0] w_pc;
    logic [7:0] w_paeth;
    logic [7:0] w_pred;

    always_comb begin
        w_ab = {1'b0, i_a} + {1'b0, i_b};
        w_cc = {i_c, 1'b0};
        w_pa = (i_b > i_c) ? (i_b - i_c) : (i_c - i_b);
        w_pb = (i_a > i_c) ? (i_a - i_c) : (i_c - i_a);
        w_pc = (w_ab > w_cc) ? (w_ab - w_cc) : (w_cc - w_ab);
        if ({1'b0, w_pa} <= {1'b0, w_pb} && {1'b0, w_pa} <= w_pc) begin
            w_paeth = i_a;
        end else if ({1'b0, w_pb} <= w_pc) begin
            w_paeth = i_b;
        end else begin
            w_paeth = i_c;
        end

        unique case (i_filter)
            png_unf_pkg::FILT_NONE:  w_pred = 8'd0;
            png_unf_pkg::FILT_SUB:   w_pred = i_a;
            png_unf_pkg::FILT_UP:    w_pred = i_b;
            png_unf_pkg::FILT_AVG:   w_pred = w_ab[8:1];
            png_unf_pkg::FILT_PAETH: w_pred = w_paeth;
            default:                 w_pred = 8'd0;
        endcase

        o_sample = i_raw + w_pred;
    end

endmodule

// ===== sv/png_scanline_unfilter_unit.sv =====
// PNG scanline unfilter, 8-bit samples, gray / rgb / gray-alpha / rgba.
// Input channel: one byte of the inflated stream per word on i_data_byte,
// taken when i_in_valid is high and o_in_stall is low. Each row opens with
// its filter byte, followed by line_width pixels of 1 to 4 samples.
// Output channel: one ARGB pixel per word on o_pixel_argb, o_last_pixel set
// on the final pixel of the image, o_bad_filter set on the one error word
// that a filter byte of 5 or more produces; after it all input is dropped
// until reset. Taken when o_out_valid is high and i_out_stall is low.
// Configuration: write color_mode, line_width, image_rows through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Throughput: one byte per cycle unless the output stalls; the prior row
// lives in a registered-read RAM whose read address is the next column.
// Latency: the pixel word is valid the cycle after its last sample byte.
// Reset (synchronous, active low) returns to waiting for a filter byte on
// the first row and clears the output valid flag; prior-row RAM is not cleared.
// A stalled output word holds; input is stalled only while an output word
// is pending and the receiver stalls.
module png_scanline_unfilter_unit #(
    parameter int MAX_WIDTH = png_unf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [31:0]                         o_pixel_argb,
    output logic                                o_last_pixel,
    output logic                                o_bad_filter
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    png_unf_pkg::t_cfg w_cfg;

    png_unf_pkg::t_filter                r_filter,    n_filter;
    logic [31:0]                         r_left,      n_left;
    logic [31:0]                         r_upleft,    n_upleft;
    logic [31:0]                         r_asm,       n_asm;
    logic [CW-1:0]                       r_column,    n_column;
    logic [1:0]                          r_sidx,      n_sidx;
    logic [png_unf_pkg::ROWS_W-1:0]      r_row,       n_row;
    logic                                r_await,     n_await;
    logic                                r_first,     n_first;
    logic                                r_failed,    n_failed;

    logic                                r_out_valid, n_out_valid;
    logic [31:0]                         r_pixel,     n_pixel;
    logic                                r_last,      n_last;
    logic                                r_bad,       n_bad;

    logic                                w_accept;
    logic [31:0]                         w_mem_q;
    logic [31:0]                         w_above;
    logic [7:0]                          w_a;
    logic [7:0]                          w_b;
    logic [7:0]                          w_c;
    logic [7:0]                          w_sample;
    logic [31:0]                         w_asm;
    logic                                w_mem_we;
    logic                                w_col_nz;

    png_unf_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    png_unf_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WIDTH)
    ) u_prior (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_column),
        .i_wdata (w_asm),
        .i_raddr (n_column),
        .o_rdata (w_mem_q)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_col_nz   = (r_column != '0);
    assign w_above    = r_first ? 32'd0 : w_mem_q;
    assign w_a        = w_col_nz ? png_unf_pkg::byte_of(r_left, r_sidx) : 8'd0;
    assign w_b        = png_unf_pkg::byte_of(w_above, r_sidx);
    assign w_c        = (w_col_nz && !r_first) ? png_unf_pkg::byte_of(r_upleft, r_sidx) : 8'd0;

    png_unf_predict u_predict (
        .i_filter (r_filter),
        .i_raw    (i_data_byte),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_c      (w_c),
        .o_sample (w_sample)
    );

    assign w_asm = png_unf_pkg::set_byte(r_asm, r_sidx, w_sample);

    always_comb begin
        n_filter    = r_filter;
        n_left      = r_left;
        n_upleft    = r_upleft;
        n_asm       = r_asm;
        n_column    = r_column;
        n_sidx      = r_sidx;
        n_row       = r_row;
        n_await     = r_await;
        n_first     = r_first;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && i_out_stall;
        n_pixel     = r_pixel;
        n_last      = r_last;
        n_bad       = r_bad;
        w_mem_we    = 1'b0;

        if (w_accept && !r_failed) begin
            if (r_await) begin
                if (i_data_byte >= png_unf_pkg::FILT_LIMIT) begin
                    n_failed    = 1'b1;
                    n_out_valid = 1'b1;
                    n_pixel     = 32'd0;
                    n_last      = 1'b0;
                    n_bad       = 1'b1;
                end else begin
                    n_filter = png_unf_pkg::t_filter'(i_data_byte[2:0]);
                    n_await  = 1'b0;
                    n_column = '0;
                    n_sidx   = 2'd0;
                    n_asm    = 32'd0;
                    n_left   = 32'd0;
                    n_upleft = 32'd0;
                end
            end else if ({1'b0, r_sidx} + 3'd1
                         < png_unf_pkg::samples_per_pixel(w_cfg.color_mode)) begin
                n_asm  = w_asm;
                n_sidx = r_sidx + 2'd1;
            end else begin
                n_out_valid = 1'b1;
                n_pixel     = png_unf_pkg::to_argb(w_cfg.color_mode, w_asm);
                n_last      = 1'b0;
                n_bad       = 1'b0;
                w_mem_we    = 1'b1;
                n_upleft    = w_above;
                n_left      = w_asm;
                n_asm       = 32'd0;
                n_sidx      = 2'd0;
                if (png_unf_pkg::CNT_W'(r_column) + png_unf_pkg::CNT_W'(1) < w_cfg.width) begin
                    n_column = r_column + CW'(1);
                end else begin
                    n_column = '0;
                    n_await  = 1'b1;
                    n_left   = 32'd0;
                    n_upleft = 32'd0;
                    if ({1'b0, r_row} + 16'd1 >= {1'b0, w_cfg.rows}) begin
                        n_last  = 1'b1;
                        n_row   = '0;
                        n_first = 1'b1;
                    end else begin
                        n_row   = r_row + png_unf_pkg::ROWS_W'(1);
                        n_first = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter    <= png_unf_pkg::FILT_NONE;
            r_left      <= 32'd0;
            r_upleft    <= 32'd0;
            r_asm       <= 32'd0;
            r_column    <= '0;
            r_sidx      <= 2'd0;
            r_row       <= '0;
            r_await     <= 1'b1;
            r_first     <= 1'b1;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_filter    <= n_filter;
            r_left      <= n_left;
            r_upleft    <= n_upleft;
            r_asm       <= n_asm;
            r_column    <= n_column;
            r_sidx      <= n_sidx;
            r_row       <= n_row;
            r_await     <= n_await;
            r_first     <= n_first;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
        r_last  <= n_last;
        r_bad   <= n_bad;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_argb = r_pixel;
    assign o_last_pixel = r_last;
    assign o_bad_filter = r_bad;

endmodule
